// File: design/pointer_cursor_tracker_top_defines.svh
// Assertion macros used by the pointer cursor tracker top level.
`ifndef POINTER_CURSOR_TRACKER_TOP_DEFINES_SVH
`define POINTER_CURSOR_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside of reset.
`define PTRK_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pointer cursor tracker assertion failed");
// Checks a property at every rising clock edge, reset included.
`define PTRK_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) (prop)) \
      else $error("pointer cursor tracker assertion failed");
`else
`define PTRK_ASSERT(name, clk, rst, prop)
`define PTRK_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// File: design/ptrk_pkg.sv
// Package with the types and constants of the pointer cursor tracker.
package ptrk_pkg;

   // Field widths.
   localparam int TIME_BITS = 16;
   localparam int X_BITS    = 10;
   localparam int Y_BITS    = 8;
   localparam int RAW_BITS  = 8;
   localparam int STEP_BITS = 8;
   localparam int WIN_BITS  = 8;
   localparam int DIR_BITS  = 4;
   localparam int BTN_BITS  = 2;

   // Signed working widths for one axis move before clamping.
   localparam int X_ARITH_BITS = X_BITS + 2;
   localparam int Y_ARITH_BITS = Y_BITS + 2;

   // Stream payload widths.
   localparam int REQ_FIELD_BITS = 2 * RAW_BITS + 3 * BTN_BITS + 2 * DIR_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * X_BITS - 1 + 2 * Y_BITS - 1 + 8;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = X_BITS;

   // Request queue between front and back.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   // Direction bit positions in joystick and key direction fields.
   localparam int DIR_UP    = 0;
   localparam int DIR_DOWN  = 1;
   localparam int DIR_LEFT  = 2;
   localparam int DIR_RIGHT = 3;

   // Bit positions in the merged active-low button pair.
   localparam int BTN_LEFT  = 1;
   localparam int BTN_RIGHT = 0;

   // Bit positions in the active-high joystick and key button fields.
   localparam int FIRE_LEFT  = 0;
   localparam int FIRE_RIGHT = 1;

   // Register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_NUDGE_STEP,
      CSR_DBL_WINDOW,
      CSR_MAX_X,
      CSR_MAX_Y,
      CSR_START_X,
      CSR_START_Y
   } csr_index_type;

   // Register reset values.
   localparam logic [STEP_BITS-1:0] NUDGE_STEP_RESET = STEP_BITS'(2);
   localparam logic [WIN_BITS-1:0]  DBL_WINDOW_RESET = WIN_BITS'(16);
   localparam logic [X_BITS-1:0]    MAX_X_RESET      = X_BITS'(319);
   localparam logic [Y_BITS-1:0]    MAX_Y_RESET      = Y_BITS'(255);
   localparam logic [X_BITS-1:0]    START_X_RESET    = X_BITS'(290);
   localparam logic [Y_BITS-1:0]    START_Y_RESET    = Y_BITS'(88);

   typedef struct packed {
      logic [STEP_BITS-1:0] nudge_step;
      logic [WIN_BITS-1:0]  dbl_window;
      logic [X_BITS-1:0]    max_x;
      logic [Y_BITS-1:0]    max_y;
      logic [X_BITS-1:0]    start_x;
      logic [Y_BITS-1:0]    start_y;
   } cfg_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      logic [RAW_BITS-1:0] raw_x;
      logic [RAW_BITS-1:0] raw_y;
      logic [BTN_BITS-1:0] buttons;
      logic [DIR_BITS-1:0] joy_dirs;
      logic [DIR_BITS-1:0] key_dirs;
   } item_type;

   // Button flags, held_l in the lowest bit.
   typedef struct packed {
      logic dbl_r;
      logic dbl_l;
      logic rel_r;
      logic rel_l;
      logic press_r;
      logic press_l;
      logic held_r;
      logic held_l;
   } flags_type;

   typedef struct packed {
      logic [X_BITS-1:0] pos_x;
      logic [Y_BITS-1:0] pos_y;
      flags_type         flags;
   } result_type;

   typedef struct packed {
      logic [QUEUE_CNT_BITS-1:0] count;
      logic                      empty;
      logic                      full;
   } queue_status_type;

endpackage

// File: design/ptrk_front.sv
// Front end: takes requests, merges the button sources and feeds the queue.
module ptrk_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata fields from bit 0: raw_x, raw_y, raw_buttons, joy_dirs,
   // joy_buttons, key_dirs, key_buttons, zero fill
   input  logic [ptrk_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  ptrk_pkg::queue_status_type        q_status,
   output logic                              push,
   output ptrk_pkg::item_type                push_item
);
   import ptrk_pkg::*;

   logic [RAW_BITS-1:0] raw_x;
   logic [RAW_BITS-1:0] raw_y;
   logic [BTN_BITS-1:0] raw_buttons;
   logic [DIR_BITS-1:0] joy_dirs;
   logic [BTN_BITS-1:0] joy_buttons;
   logic [DIR_BITS-1:0] key_dirs;
   logic [BTN_BITS-1:0] key_buttons;

   // Unpack the request fields.
   assign {key_buttons, key_dirs, joy_buttons, joy_dirs, raw_buttons, raw_y, raw_x} =
      req_tdata[REQ_FIELD_BITS-1:0];

   // Accept whenever the queue has room.
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full;

   // Merge buttons: a joystick or key fire pulls the active-low mouse bit down.
   always_comb begin
      push_item.raw_x    = raw_x;
      push_item.raw_y    = raw_y;
      push_item.joy_dirs = joy_dirs;
      push_item.key_dirs = key_dirs;
      push_item.buttons[BTN_LEFT] = raw_buttons[BTN_LEFT] &
         !joy_buttons[FIRE_LEFT] & !key_buttons[FIRE_LEFT];
      push_item.buttons[BTN_RIGHT] = raw_buttons[BTN_RIGHT] &
         !joy_buttons[FIRE_RIGHT] & !key_buttons[FIRE_RIGHT];
   end

endmodule

// File: design/ptrk_queue.sv
// Short request queue that decouples the front end from the back end.
module ptrk_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ptrk_pkg::item_type         push_item,
   input  logic                       pop,
   output ptrk_pkg::item_type         pop_item,
   output ptrk_pkg::queue_status_type q_status
);
   import ptrk_pkg::*;

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item       = entry_ff[rd_ptr_ff];
   assign q_status.count = count_ff;
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));

endmodule

// File: design/ptrk_back.sv
// Back end: moves the cursor, judges the buttons and holds the response.
module ptrk_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ptrk_pkg::cfg_type          cfg,
   input  ptrk_pkg::queue_status_type q_status,
   input  ptrk_pkg::item_type         item,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ptrk_pkg::result_type       result
);
   import ptrk_pkg::*;

   logic [X_BITS-1:0]    cursor_x_ff, cursor_x_in;
   logic [Y_BITS-1:0]    cursor_y_ff, cursor_y_in;
   logic [RAW_BITS-1:0]  last_raw_x_ff, last_raw_x_in;
   logic [RAW_BITS-1:0]  last_raw_y_ff, last_raw_y_in;
   logic                 primed_ff, primed_in;
   logic [BTN_BITS-1:0]  last_btn_ff, last_btn_in;
   logic [BTN_BITS-1:0]  older_btn_ff, older_btn_in;
   logic [TIME_BITS-1:0] frame_ff, frame_in;
   logic [TIME_BITS-1:0] click_l_ff, click_l_in;
   logic [TIME_BITS-1:0] click_r_ff, click_r_in;
   flags_type            flags_ff, flags_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff, out_in;

   // Adds a signed delta to the horizontal position and clamps to 0..hi.
   function automatic logic [X_BITS-1:0] move_x(input logic [X_BITS-1:0] cur,
                                                input logic signed [X_ARITH_BITS-1:0] delta,
                                                input logic [X_BITS-1:0] hi);
      logic signed [X_ARITH_BITS-1:0] sum;
      logic signed [X_ARITH_BITS-1:0] hi_s;
      sum  = signed'({{(X_ARITH_BITS-X_BITS){1'b0}}, cur}) + delta;
      hi_s = signed'({{(X_ARITH_BITS-X_BITS){1'b0}}, hi});
      if (sum < 0) begin
         return '0;
      end else if (sum > hi_s) begin
         return hi;
      end else begin
         return sum[X_BITS-1:0];
      end
   endfunction

   // Adds a signed delta to the vertical position and clamps to 0..hi.
   function automatic logic [Y_BITS-1:0] move_y(input logic [Y_BITS-1:0] cur,
                                                input logic signed [Y_ARITH_BITS-1:0] delta,
                                                input logic [Y_BITS-1:0] hi);
      logic signed [Y_ARITH_BITS-1:0] sum;
      logic signed [Y_ARITH_BITS-1:0] hi_s;
      sum  = signed'({{(Y_ARITH_BITS-Y_BITS){1'b0}}, cur}) + delta;
      hi_s = signed'({{(Y_ARITH_BITS-Y_BITS){1'b0}}, hi});
      if (sum < 0) begin
         return '0;
      end else if (sum > hi_s) begin
         return hi;
      end else begin
         return sum[Y_BITS-1:0];
      end
   endfunction

   logic signed [X_ARITH_BITS-1:0] step_x;
   logic signed [Y_ARITH_BITS-1:0] step_y;
   logic [RAW_BITS-1:0]            dx_raw;
   logic [RAW_BITS-1:0]            dy_raw;
   logic signed [X_ARITH_BITS-1:0] dx;
   logic signed [Y_ARITH_BITS-1:0] dy;
   logic                           mouse_moved;
   logic [X_BITS-1:0]              nx;
   logic [Y_BITS-1:0]              ny;
   logic                           down_l, was_l, down_r, was_r;
   logic                           within_l, within_r;
   logic [TIME_BITS-1:0]           elapsed_l, elapsed_r;
   logic [TIME_BITS-1:0]           window;
   flags_type                      eval_flags;

   // Steps and wrapped mouse deltas.
   assign step_x      = signed'({{(X_ARITH_BITS-STEP_BITS){1'b0}}, cfg.nudge_step});
   assign step_y      = signed'({{(Y_ARITH_BITS-STEP_BITS){1'b0}}, cfg.nudge_step});
   assign dx_raw      = item.raw_x - last_raw_x_ff;
   assign dy_raw      = last_raw_y_ff - item.raw_y;
   assign dx          = signed'({{(X_ARITH_BITS-RAW_BITS){dx_raw[RAW_BITS-1]}}, dx_raw});
   assign dy          = signed'({{(Y_ARITH_BITS-RAW_BITS){dy_raw[RAW_BITS-1]}}, dy_raw});
   assign mouse_moved = (item.raw_x != last_raw_x_ff) || (item.raw_y != last_raw_y_ff);
   assign window      = {{(TIME_BITS-WIN_BITS){1'b0}}, cfg.dbl_window};

   // Cursor chain: joystick, then keys, then mouse, clamped after each move.
   always_comb begin
      nx = cursor_x_ff;
      ny = cursor_y_ff;
      if (item.joy_dirs[DIR_UP])    ny = move_y(ny, -step_y, cfg.max_y);
      if (item.joy_dirs[DIR_DOWN])  ny = move_y(ny, step_y, cfg.max_y);
      if (item.joy_dirs[DIR_LEFT])  nx = move_x(nx, -step_x, cfg.max_x);
      if (item.joy_dirs[DIR_RIGHT]) nx = move_x(nx, step_x, cfg.max_x);
      if (item.key_dirs[DIR_UP])    ny = move_y(ny, -step_y, cfg.max_y);
      if (item.key_dirs[DIR_DOWN])  ny = move_y(ny, step_y, cfg.max_y);
      if (item.key_dirs[DIR_LEFT])  nx = move_x(nx, -step_x, cfg.max_x);
      if (item.key_dirs[DIR_RIGHT]) nx = move_x(nx, step_x, cfg.max_x);
      if (mouse_moved) begin
         nx = move_x(nx, dx, cfg.max_x);
         ny = move_y(ny, dy, cfg.max_y);
      end
   end

   // Button edges against the previous merged value; buttons are active low.
   assign down_l    = !item.buttons[BTN_LEFT];
   assign was_l     = !last_btn_ff[BTN_LEFT];
   assign down_r    = !item.buttons[BTN_RIGHT];
   assign was_r     = !last_btn_ff[BTN_RIGHT];
   assign elapsed_l = frame_ff - click_l_ff;
   assign elapsed_r = frame_ff - click_r_ff;
   assign within_l  = (elapsed_l <= window);
   assign within_r  = (elapsed_r <= window);

   always_comb begin
      eval_flags.held_l  = down_l;
      eval_flags.held_r  = down_r;
      eval_flags.press_l = (down_l != was_l) && down_l;
      eval_flags.press_r = (down_r != was_r) && down_r;
      eval_flags.rel_l   = (down_l != was_l) && !down_l;
      eval_flags.rel_r   = (down_r != was_r) && !down_r;
      eval_flags.dbl_l   = eval_flags.rel_l && within_l;
      eval_flags.dbl_r   = eval_flags.rel_r && within_r;
   end

   // The next request is taken when the response slot is free or draining.
   assign pop = !q_status.empty && (!out_valid_ff || rsp_ready);

   // Frame state update and response register.
   always_comb begin
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      last_raw_x_in = last_raw_x_ff;
      last_raw_y_in = last_raw_y_ff;
      primed_in     = primed_ff;
      last_btn_in   = last_btn_ff;
      older_btn_in  = older_btn_ff;
      frame_in      = frame_ff;
      click_l_in    = click_l_ff;
      click_r_in    = click_r_ff;
      flags_in      = flags_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      if (pop) begin
         if (!primed_ff) begin
            // First frame after reset only captures the counters and loads the start position.
            primed_in     = 1'b1;
            last_raw_x_in = item.raw_x;
            last_raw_y_in = item.raw_y;
            cursor_x_in   = cfg.start_x;
            cursor_y_in   = cfg.start_y;
         end else begin
            cursor_x_in = nx;
            cursor_y_in = ny;
            if (mouse_moved) begin
               last_raw_x_in = item.raw_x;
               last_raw_y_in = item.raw_y;
            end
            // Steady buttons keep the previous flags.
            if (!((item.buttons == last_btn_ff) && (item.buttons == older_btn_ff))) begin
               flags_in     = eval_flags;
               older_btn_in = last_btn_ff;
               last_btn_in  = item.buttons;
               if (eval_flags.rel_l && !within_l) click_l_in = frame_ff;
               if (eval_flags.rel_r && !within_r) click_r_in = frame_ff;
            end
            frame_in = frame_ff + 1'b1;
         end
         out_valid_in = 1'b1;
         out_in.pos_x = cursor_x_in;
         out_in.pos_y = cursor_y_in;
         out_in.flags = flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff   <= START_X_RESET;
         cursor_y_ff   <= START_Y_RESET;
         last_raw_x_ff <= '0;
         last_raw_y_ff <= '0;
         primed_ff     <= 1'b0;
         last_btn_ff   <= '0;
         older_btn_ff  <= '0;
         frame_ff      <= '0;
         click_l_ff    <= '0;
         click_r_ff    <= '0;
         flags_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         last_raw_x_ff <= last_raw_x_in;
         last_raw_y_ff <= last_raw_y_in;
         primed_ff     <= primed_in;
         last_btn_ff   <= last_btn_in;
         older_btn_ff  <= older_btn_in;
         frame_ff      <= frame_in;
         click_l_ff    <= click_l_in;
         click_r_ff    <= click_r_in;
         flags_ff      <= flags_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign result    = out_ff;

endmodule

// File: design/pointer_cursor_tracker_top.sv
// Top level of the pointer cursor tracker: register file, front, queue and back.
//
// Each request on the req_ stream is one video frame: raw mouse counters, mouse
// buttons, and joystick and key direction and fire bits. Each request gives
// exactly one response on the rsp_ stream with the clamped cursor position, its
// halves and the held, pressed, released and double-click button flags.
// Registers are written on the csr_ port (write enable, index, data); the user must
// write them only while the block is idle, which the block itself does not enforce.
// Indexes past the last register are ignored. When the block is empty, an accepted
// request is written into the queue and then into the response register, which
// raises rsp_tvalid. One request per cycle is sustained while rsp_tready stays high;
// the back end updates the cursor and button state as it takes each frame.
// A two-entry queue separates the front end from the back end, and the response
// sits in an output register, so a new request is accepted while a response
// still waits. When the receiver stalls, the response holds, the queue fills and
// req_tready drops once both entries are taken.
// Reset (synchronous, active high) restores the register defaults, empties the
// queue and clears the frame state; the first frame after reset only captures
// the mouse counters and reports the start position.
`include "pointer_cursor_tracker_top_defines.svh"

module pointer_cursor_tracker_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata fields from bit 0: raw_x, raw_y, raw_buttons, joy_dirs,
   // joy_buttons, key_dirs, key_buttons, zero fill
   input  logic [ptrk_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata fields from bit 0: pos_x, pos_y, half_x, half_y, held_left,
   // held_right, pressed_left, pressed_right, released_left, released_right,
   // double_left, double_right, zero fill
   output logic [ptrk_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [ptrk_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ptrk_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import ptrk_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             push;
   logic             pop;
   item_type         push_item;
   item_type         pop_item;
   result_type       result;

   // Register file.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_NUDGE_STEP: cfg_in.nudge_step = csr_wdata[STEP_BITS-1:0];
            CSR_DBL_WINDOW: cfg_in.dbl_window = csr_wdata[WIN_BITS-1:0];
            CSR_MAX_X:      cfg_in.max_x      = csr_wdata[X_BITS-1:0];
            CSR_MAX_Y:      cfg_in.max_y      = csr_wdata[Y_BITS-1:0];
            CSR_START_X:    cfg_in.start_x    = csr_wdata[X_BITS-1:0];
            CSR_START_Y:    cfg_in.start_y    = csr_wdata[Y_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nudge_step <= NUDGE_STEP_RESET;
         cfg_ff.dbl_window <= DBL_WINDOW_RESET;
         cfg_ff.max_x      <= MAX_X_RESET;
         cfg_ff.max_y      <= MAX_Y_RESET;
         cfg_ff.start_x    <= START_X_RESET;
         cfg_ff.start_y    <= START_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptrk_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   ptrk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   ptrk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .item      (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .result    (result)
   );

   // Pack the response.
   assign rsp_tdata = {{(RSP_DATA_BITS-RSP_FIELD_BITS){1'b0}},
                       result.flags,
                       result.pos_y[Y_BITS-1:1],
                       result.pos_x[X_BITS-1:1],
                       result.pos_y,
                       result.pos_x};

   // The response to a request into an empty block is offered once it passes the queue and the response register.
   `PTRK_ASSERT(a_empty_latency, clock, reset,
      (req_tvalid && req_tready && q_status.empty && !rsp_tvalid) |-> ##2 rsp_tvalid)

   // The queue grows by one on a push without a pop.
   `PTRK_ASSERT(a_queue_grows, clock, reset,
      (push && !pop) |=> (q_status.count == $past(q_status.count) + 1'b1))

   // A double click is always a release of the same button.
   `PTRK_ASSERT(a_double_is_release, clock, reset,
      rsp_tvalid |-> ((!result.flags.dbl_l || result.flags.rel_l) &&
                      (!result.flags.dbl_r || result.flags.rel_r)))

   // No button is reported pressed and released in the same frame.
   `PTRK_ASSERT(a_press_or_release, clock, reset,
      rsp_tvalid |-> (!(result.flags.press_l && result.flags.rel_l) &&
                      !(result.flags.press_r && result.flags.rel_r)))

endmodule

// File: test/tb_pointer_cursor_tracker_top.sv
// Testbench for the pointer cursor tracker: request driver, cursor predictor and response checker.
`timescale 1ns / 100ps

module tb_pointer_cursor_tracker_top;
   import ptrk_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int PRINT_CAP   = 30;

   // One expected response: position, halves and the eight button flags.
   typedef struct packed {
      logic [X_BITS-1:0]   pos_x;
      logic [Y_BITS-1:0]   pos_y;
      logic [X_BITS-2:0]   half_x;
      logic [Y_BITS-2:0]   half_y;
      flags_type           flags;
   } cursor_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_wr_en  = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index  = CSR_NUDGE_STEP;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   pointer_cursor_tracker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Frames waiting to be sent and responses the predictor expects.
   logic [REQ_DATA_BITS-1:0] frame_queue [$];
   cursor_type               cursor_expect_q [$];

   // Predictor copy of the registers.
   logic [STEP_BITS-1:0] cfg_step    = NUDGE_STEP_RESET;
   logic [WIN_BITS-1:0]  cfg_window  = DBL_WINDOW_RESET;
   logic [X_BITS-1:0]    cfg_max_x   = MAX_X_RESET;
   logic [Y_BITS-1:0]    cfg_max_y   = MAX_Y_RESET;
   logic [X_BITS-1:0]    cfg_start_x = START_X_RESET;
   logic [Y_BITS-1:0]    cfg_start_y = START_Y_RESET;

   // Predictor copy of the frame state.
   int                   cur_x       = int'(START_X_RESET);
   int                   cur_y       = int'(START_Y_RESET);
   logic [RAW_BITS-1:0]  seen_raw_x  = '0;
   logic [RAW_BITS-1:0]  seen_raw_y  = '0;
   logic                 primed_flag = 1'b0;
   logic [BTN_BITS-1:0]  btn_last    = '0;
   logic [BTN_BITS-1:0]  btn_older   = '0;
   logic [TIME_BITS-1:0] frame_ctr   = '0;
   logic [TIME_BITS-1:0] click_stamp [2] = '{'0, '0};
   flags_type            flag_reg    = '0;

   // Run bookkeeping.
   int errors          = 0;
   int rsp_count       = 0;
   int frames_sent     = 0;
   int settings_loaded = 0;
   int presses_seen    = 0;
   int doubles_seen    = 0;
   int cycle_count     = 0;

   // Random frame generator state: mouse counters and mouse buttons.
   logic [RAW_BITS-1:0] gen_x   = '0;
   logic [RAW_BITS-1:0] gen_y   = '0;
   logic [BTN_BITS-1:0] gen_btn = 2'b11;

   task automatic report_mismatch(string msg);
      if (errors < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   function automatic int clamp_axis(int v, int hi);
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      return v;
   endfunction

   // Moves the cursor by the nudge step for each set direction bit, in fixed order.
   function automatic void step_dirs(logic [DIR_BITS-1:0] dirs);
      int s;
      s = int'(cfg_step);
      if (dirs[DIR_UP])    cur_y = clamp_axis(cur_y - s, int'(cfg_max_y));
      if (dirs[DIR_DOWN])  cur_y = clamp_axis(cur_y + s, int'(cfg_max_y));
      if (dirs[DIR_LEFT])  cur_x = clamp_axis(cur_x - s, int'(cfg_max_x));
      if (dirs[DIR_RIGHT]) cur_x = clamp_axis(cur_x + s, int'(cfg_max_x));
   endfunction

   // Judges one active-low button; returns {double, released, pressed, held}.
   function automatic logic [3:0] judge_button(logic [BTN_BITS-1:0] merged, int pos);
      logic           down;
      logic           was_down;
      logic [3:0]     f;
      logic [TIME_BITS-1:0] age;
      down     = !merged[pos];
      was_down = !btn_last[pos];
      f        = {3'b000, down};
      age      = frame_ctr - click_stamp[pos];
      if (down && !was_down) begin
         f[1] = 1'b1;
      end else if (!down && was_down) begin
         f[2] = 1'b1;
         if (age <= TIME_BITS'(cfg_window))
            f[3] = 1'b1;
         else
            click_stamp[pos] = frame_ctr;
      end
      return f;
   endfunction

   // Advances the cursor state by one frame and returns the response it gives.
   function automatic cursor_type track_frame(logic [REQ_DATA_BITS-1:0] d);
      logic [RAW_BITS-1:0] rx;
      logic [RAW_BITS-1:0] ry;
      logic [BTN_BITS-1:0] merged;
      logic [BTN_BITS-1:0] jb;
      logic [BTN_BITS-1:0] kb;
      logic [RAW_BITS-1:0] dlt;
      logic [3:0]          bl;
      logic [3:0]          br;
      cursor_type          r;
      rx     = d[7:0];
      ry     = d[15:8];
      merged = d[17:16];
      jb     = d[23:22];
      kb     = d[29:28];
      if (!primed_flag) begin
         // The first frame only captures the counters and loads the start position.
         primed_flag = 1'b1;
         seen_raw_x  = rx;
         seen_raw_y  = ry;
         cur_x       = int'(cfg_start_x);
         cur_y       = int'(cfg_start_y);
      end else begin
         step_dirs(d[21:18]);
         step_dirs(d[27:24]);
         if (rx != seen_raw_x || ry != seen_raw_y) begin
            dlt = rx - seen_raw_x;
            cur_x = clamp_axis(cur_x + int'($signed(dlt)), int'(cfg_max_x));
            dlt = seen_raw_y - ry;
            cur_y = clamp_axis(cur_y + int'($signed(dlt)), int'(cfg_max_y));
            seen_raw_x = rx;
            seen_raw_y = ry;
         end
         if (jb[FIRE_LEFT] || kb[FIRE_LEFT])   merged[BTN_LEFT]  = 1'b0;
         if (jb[FIRE_RIGHT] || kb[FIRE_RIGHT]) merged[BTN_RIGHT] = 1'b0;
         // Buttons steady over three evaluations keep the previous flags.
         if (!(merged == btn_last && merged == btn_older)) begin
            bl = judge_button(merged, BTN_LEFT);
            br = judge_button(merged, BTN_RIGHT);
            flag_reg  = {br[3], bl[3], br[2], bl[2], br[1], bl[1], br[0], bl[0]};
            btn_older = btn_last;
            btn_last  = merged;
         end
         frame_ctr = frame_ctr + 1'b1;
      end
      r.pos_x  = X_BITS'(cur_x);
      r.pos_y  = Y_BITS'(cur_y);
      r.half_x = r.pos_x[X_BITS-1:1];
      r.half_y = r.pos_y[Y_BITS-1:1];
      r.flags  = flag_reg;
      return r;
   endfunction

   task automatic queue_frame(logic [7:0] rx, logic [7:0] ry, logic [1:0] mb,
                              logic [3:0] jd, logic [1:0] jb, logic [3:0] kd,
                              logic [1:0] kb);
      frame_queue.push_back(REQ_DATA_BITS'({kb, kd, jb, jd, mb, ry, rx}));
   endtask

   // Random frames: mostly small mouse steps and sparse button changes, so that
   // presses, releases and double clicks happen often.
   task automatic queue_random_frames(int count);
      logic [DIR_BITS-1:0] jd;
      logic [DIR_BITS-1:0] kd;
      logic [BTN_BITS-1:0] jb;
      logic [BTN_BITS-1:0] kb;
      repeat (count) begin
         case ($urandom_range(0, 7))
            0, 1: ;
            2: begin
               gen_x = RAW_BITS'($urandom);
               gen_y = RAW_BITS'($urandom);
            end
            default: begin
               gen_x = 8'(gen_x + $urandom_range(0, 16) - 8);
               gen_y = 8'(gen_y + $urandom_range(0, 16) - 8);
            end
         endcase
         if ($urandom_range(0, 2) == 0) gen_btn = BTN_BITS'($urandom_range(0, 3));
         jd = ($urandom_range(0, 1) == 0) ? DIR_BITS'($urandom) : '0;
         kd = ($urandom_range(0, 1) == 0) ? DIR_BITS'($urandom) : '0;
         jb = ($urandom_range(0, 7) == 0) ? BTN_BITS'($urandom) : '0;
         kb = ($urandom_range(0, 7) == 0) ? BTN_BITS'($urandom) : '0;
         queue_frame(gen_x, gen_y, gen_btn, jd, jb, kd, kb);
      end
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_NUDGE_STEP: cfg_step    = val[STEP_BITS-1:0];
         CSR_DBL_WINDOW: cfg_window  = val[WIN_BITS-1:0];
         CSR_MAX_X:      cfg_max_x   = val[X_BITS-1:0];
         CSR_MAX_Y:      cfg_max_y   = val[Y_BITS-1:0];
         CSR_START_X:    cfg_start_x = val[X_BITS-1:0];
         CSR_START_Y:    cfg_start_y = val[Y_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_settings(int step, int win, int mx, int my, int sx, int sy);
      write_register(CSR_NUDGE_STEP, CSR_DATA_BITS'(step));
      write_register(CSR_DBL_WINDOW, CSR_DATA_BITS'(win));
      write_register(CSR_MAX_X, CSR_DATA_BITS'(mx));
      write_register(CSR_MAX_Y, CSR_DATA_BITS'(my));
      write_register(CSR_START_X, CSR_DATA_BITS'(sx));
      write_register(CSR_START_Y, CSR_DATA_BITS'(sy));
      settings_loaded++;
   endtask

   // Waits until every frame is sent and answered, then lets the pipeline drain.
   task automatic wait_idle();
      while (frame_queue.size() != 0 || req_tvalid || cursor_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            cursor_expect_q.push_back(track_frame(req_tdata));
            frames_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (frame_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= frame_queue.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response checker and receiver stall pattern, with two long hold-offs.
   string field_names [12] = '{"pos_x", "pos_y", "half_x", "half_y", "held_left",
      "held_right", "pressed_left", "pressed_right", "released_left",
      "released_right", "double_left", "double_right"};
   logic [9:0] got_f  [12];
   logic [9:0] want_f [12];
   cursor_type want_rsp;
   int         fld;
   int         hold_left  = 0;
   int         stall_age  = 0;
   int         stall_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cursor_expect_q.size() == 0) begin
               report_mismatch($sformatf("response %h with no frame waiting", rsp_tdata));
            end else begin
               want_rsp = cursor_expect_q.pop_front();
               got_f  = '{10'(rsp_tdata[9:0]), 10'(rsp_tdata[17:10]),
                          10'(rsp_tdata[26:18]), 10'(rsp_tdata[33:27]),
                          10'(rsp_tdata[34]), 10'(rsp_tdata[35]), 10'(rsp_tdata[36]),
                          10'(rsp_tdata[37]), 10'(rsp_tdata[38]), 10'(rsp_tdata[39]),
                          10'(rsp_tdata[40]), 10'(rsp_tdata[41])};
               want_f = '{10'(want_rsp.pos_x), 10'(want_rsp.pos_y),
                          10'(want_rsp.half_x), 10'(want_rsp.half_y),
                          10'(want_rsp.flags.held_l), 10'(want_rsp.flags.held_r),
                          10'(want_rsp.flags.press_l), 10'(want_rsp.flags.press_r),
                          10'(want_rsp.flags.rel_l), 10'(want_rsp.flags.rel_r),
                          10'(want_rsp.flags.dbl_l), 10'(want_rsp.flags.dbl_r)};
               for (fld = 0; fld < 12; fld++)
                  if (got_f[fld] !== want_f[fld])
                     report_mismatch($sformatf("response %0d %s: got %0d, want %0d",
                        rsp_count, field_names[fld], got_f[fld], want_f[fld]));
               if (want_rsp.flags.press_l || want_rsp.flags.press_r) presses_seen++;
               if (want_rsp.flags.dbl_l || want_rsp.flags.dbl_r) doubles_seen++;
            end
            rsp_count++;
            if (rsp_count == 120 || rsp_count == 330) hold_left = HOLD_CYCLES;
         end
         if (stall_age == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_age  = 50;
         end
         stall_age--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (stall_age % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run limit of %0d cycles reached.", CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus sequence.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Start position at its extremes, above the default horizontal clamp.
      write_register(CSR_START_X, CSR_DATA_BITS'(1023));
      write_register(CSR_START_Y, CSR_DATA_BITS'(0));

      // Priming frame, then steady buttons and unchanged counters.
      queue_frame(8'h10, 8'h20, 2'b00, 4'hF, 2'b11, 4'hF, 2'b11);
      queue_frame(8'h10, 8'h20, 2'b00, 4'h0, 2'b00, 4'h0, 2'b00);
      // Nudges that clamp at zero and at the horizontal maximum.
      queue_frame(8'h10, 8'h20, 2'b00, 4'b0001, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h10, 8'h20, 2'b00, 4'h0, 2'b00, 4'b0100, 2'b00);
      // Largest positive and negative wrapped mouse deltas.
      queue_frame(8'h8F, 8'h20, 2'b00, 4'b1000, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h0F, 8'hA0, 2'b00, 4'h0, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h0F, 8'h21, 2'b00, 4'h0, 2'b00, 4'h0, 2'b00);
      // Releases, presses and double clicks from every button source.
      queue_frame(8'h0F, 8'h21, 2'b11, 4'h0, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h0F, 8'h21, 2'b01, 4'h0, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h0F, 8'h21, 2'b11, 4'h0, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h0F, 8'h21, 2'b11, 4'h0, 2'b01, 4'h0, 2'b00);
      queue_frame(8'h0F, 8'h21, 2'b11, 4'h0, 2'b00, 4'h0, 2'b10);
      queue_frame(8'hFF, 8'hFF, 2'b11, 4'b1010, 2'b00, 4'b1010, 2'b00);
      queue_frame(8'hFF, 8'hFF, 2'b11, 4'h0, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h00, 8'h00, 2'b11, 4'b0110, 2'b00, 4'b1001, 2'b00);
      queue_frame(8'h00, 8'h00, 2'b10, 4'h0, 2'b00, 4'h0, 2'b00);
      wait_idle();

      // Extreme step, zero window, vertical clamp lowered below the position.
      load_settings(255, 0, 1023, 0, 0, 255);
      queue_frame(8'h00, 8'h00, 2'b10, 4'h0, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h00, 8'h00, 2'b11, 4'b1000, 2'b00, 4'h0, 2'b00);
      queue_frame(8'h00, 8'h00, 2'b11, 4'h0, 2'b00, 4'b0010, 2'b00);
      queue_frame(8'h01, 8'h00, 2'b11, 4'h0, 2'b00, 4'h0, 2'b00);
      gen_x = 8'h01;
      gen_y = 8'h00;
      queue_random_frames(80);
      wait_idle();

      // Zero step, widest window, horizontal clamp at zero.
      load_settings(0, 255, 0, 255, 512, 128);
      queue_random_frames(80);
      wait_idle();

      // Random mid-range settings.
      load_settings($urandom_range(1, 8), $urandom_range(0, 255), $urandom_range(100, 1023),
                    $urandom_range(50, 255), $urandom_range(0, 1023), $urandom_range(0, 255));
      queue_random_frames(100);
      wait_idle();

      // Unit step with the full position range.
      load_settings(1, 255, 1023, 255, 0, 0);
      queue_random_frames(60);
      wait_idle();

      // Settings near the defaults with a tighter vertical clamp.
      load_settings(3, 16, 319, 200, 290, 88);
      queue_random_frames(60);
      wait_idle();

      $display("Checked %0d responses to %0d frames over %0d register settings.",
               rsp_count, frames_sent, settings_loaded);
      $display("Frames held %0d presses and %0d double clicks from all button sources.",
               presses_seen, doubles_seen);
      if (errors == 0 && cursor_expect_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: pointer_cursor_tracker_top.f
+incdir+design
design/ptrk_pkg.sv
design/ptrk_front.sv
design/ptrk_queue.sv
design/ptrk_back.sv
design/pointer_cursor_tracker_top.sv
test/tb_pointer_cursor_tracker_top.sv
